// ===== src/ucb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucb_pkg
// Types, widths and constants shared by the UCB1 arm selector and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package ucb_pkg;

  localparam int NUM_ARMS = 8;
  localparam int ARM_W    = 3;
  localparam int MASK_W   = 8;
  localparam int SCORE_W  = 48;
  localparam int PULL_W   = 32;
  localparam int VAL_W    = 31;
  localparam int GAIN_W   = 16;
  localparam int LOG_W    = 21;
  localparam int T_W      = 37;
  localparam int SQ_W     = 46;
  localparam int ROOT_W   = 23;
  localparam int CMPV_W   = SCORE_W + 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_RELATIVE = 2'd1;

  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_REWARD = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [MASK_W-1:0] arm_available;
    logic [VAL_W-1:0]  new_value;
  } ucb_in_t;

  typedef struct packed {
    logic [ARM_W-1:0] chosen_arm;
    logic             arm_found;
    logic             improved;
  } ucb_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ucb_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL_INIT,
    S_SEL_LOG,
    S_SEL_LN,
    S_SEL_T,
    S_SEL_ARM,
    S_SEL_MEAN,
    S_SEL_Q,
    S_SEL_SQRT,
    S_SEL_CMP,
    S_SEL_END,
    S_REW,
    S_REW_DIV,
    S_DONE
  } ucb_state_t;

  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                 input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/ucb_div.sv =====
// ----------------------------------------------------------------------------
// ucb_div
// Restoring divider, 48-bit dividend by 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ucb_pkg::SCORE_W-1:0]  num,
  input  wire logic [ucb_pkg::PULL_W-1:0]   den,
  output logic      [ucb_pkg::SCORE_W-1:0]  quot,
  output ucb_pkg::ucb_stat_t                stat
);
  import ucb_pkg::*;

  logic [PULL_W-1:0] rem;
  logic [PULL_W-1:0] den_q;
  logic [5:0]        cnt;
  logic              busy;
  logic              done;
  logic [PULL_W:0]   rem_sh;

  assign rem_sh = {rem, quot[SCORE_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'(SCORE_W);
        quot  <= num;
        rem   <= '0;
        den_q <= den;
      end else if (busy) begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem  <= PULL_W'(rem_sh - {1'b0, den_q});
          quot <= {quot[SCORE_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[PULL_W-1:0];
          quot <= {quot[SCORE_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

`default_nettype wire

// ===== src/ucb_log2.sv =====
// ----------------------------------------------------------------------------
// ucb_log2
// Base-2 logarithm in Q.16, one fraction bit a cycle by repeated squaring.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_log2 (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ucb_pkg::PULL_W-1:0] v,
  output logic      [ucb_pkg::LOG_W-1:0]  r,
  output ucb_pkg::ucb_stat_t              stat
);
  import ucb_pkg::*;

  logic [4:0]  e_in;
  logic [4:0]  e_q;
  logic [15:0] frac;
  logic [31:0] x;
  logic [3:0]  bcnt;
  logic        busy;
  logic        done;
  logic [63:0] sq;
  logic [32:0] y;

  always_comb begin
    e_in = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) e_in = 5'(i);
    end
  end

  assign sq = 64'(x) * 64'(x);
  assign y  = sq[63:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bcnt <= 4'd15;
        e_q  <= e_in;
        frac <= '0;
        x    <= v << (5'd31 - e_in);
      end else if (busy) begin
        if (y[32]) begin
          x          <= y[32:1];
          frac[bcnt] <= 1'b1;
        end else begin
          x <= y[31:0];
        end
        bcnt <= bcnt - 4'd1;
        if (bcnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign r    = {e_q, frac};
  assign stat = '{busy: busy, done: done};

endmodule

`default_nettype wire

// ===== src/ucb_isqrt.sv =====
// ----------------------------------------------------------------------------
// ucb_isqrt
// Integer square root, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ucb_pkg::SQ_W-1:0]   n_in,
  output logic      [ucb_pkg::ROOT_W-1:0] root,
  output ucb_pkg::ucb_stat_t              stat
);
  import ucb_pkg::*;

  logic [SQ_W-1:0] n;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;
  logic            busy;
  logic            done;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= n_in;
        res  <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy) begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[ROOT_W-1:0];
  assign stat = '{busy: busy, done: done};

endmodule

`default_nettype wire

// ===== src/ucb_bandit_arm_selector.sv =====
// ----------------------------------------------------------------------------
// ucb_bandit_arm_selector
// UCB1 arm chooser: scores available arms and picks the best, takes rewards.
// ----------------------------------------------------------------------------
//   channel | signals                          | transfer
//   in      | in_valid, in_ready, in_data      | in_valid & in_ready
//   out     | out_valid, out_ready, out_data   | out_valid & out_ready
//   cfg     | cfg_write, cfg_index, cfg_data   | cfg_write
//
// select: the logarithm of the total pulls first, then per scored arm a divider run
//   for the mean, another for the exploration term and a square root
// reward: goes through the divider in relative mode when the value improves
// one item at a time; the result register frees the input side while it waits
// synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_bandit_arm_selector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ucb_pkg::ucb_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ucb_pkg::ucb_out_t                  out_data,
  input  wire logic                          cfg_write,
  input  wire logic [ucb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ucb_pkg::CFG_W-1:0]     cfg_data
);
  import ucb_pkg::*;

  ucb_state_t state, state_next;

  logic [GAIN_W-1:0]  explore_gain;
  logic               count_once;
  logic [1:0]         reward_mode;

  logic [SCORE_W-1:0] arm_score [NUM_ARMS];
  logic [PULL_W-1:0]  arm_pulls [NUM_ARMS];
  logic [VAL_W-1:0]   best_seen [NUM_ARMS];
  logic [VAL_W-1:0]   first_seen [NUM_ARMS];
  logic [NUM_ARMS-1:0] best_valid;
  logic [PULL_W-1:0]  total_pulls;
  logic [ARM_W-1:0]   selected_arm;
  logic               fresh_selection;

  logic [MASK_W-1:0]  mask_q;
  logic [VAL_W-1:0]   key_q;
  logic [ARM_W-1:0]   arm;
  logic               found;
  logic [ARM_W-1:0]   best_arm;
  logic [CMPV_W-1:0]  best_val;
  logic [CMPV_W-1:0]  val_q;
  logic [SCORE_W-1:0] mean_q;
  logic [LOG_W-1:0]   ln_q;
  logic [T_W-1:0]     t_q;
  ucb_out_t           res_q;

  logic               div_start;
  logic [SCORE_W-1:0] div_num;
  logic [PULL_W-1:0]  div_den;
  logic [SCORE_W-1:0] div_quot;
  ucb_stat_t          div_stat;
  logic               log_start;
  logic [LOG_W-1:0]   log_r;
  ucb_stat_t          log_stat;
  logic               sqrt_start;
  logic [ROOT_W-1:0]  root;
  ucb_stat_t          sqrt_stat;

  logic               out_free;
  logic               last_arm;
  logic               arm_inf;
  logic [52:0]        ln_prod;
  logic [VAL_W-1:0]   rew_best;
  logic               rew_imp;
  logic               rew_rel;
  logic [VAL_W-1:0]   rew_drop;

  ucb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quot(div_quot), .stat(div_stat)
  );

  ucb_log2 u_log2 (
    .clk(clk), .rst(rst), .start(log_start), .v(total_pulls),
    .r(log_r), .stat(log_stat)
  );

  ucb_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .n_in({1'b0, div_quot[T_W-1:0], 8'h00}), .root(root), .stat(sqrt_stat)
  );

  assign out_free = !out_valid || out_ready;
  assign last_arm = (arm == ARM_W'(NUM_ARMS - 1));
  assign arm_inf  = (total_pulls == '0) || (arm_pulls[arm] == '0);
  assign ln_prod  = 53'(log_r) * 53'(LN2_Q32);
  assign in_ready = (state == S_IDLE);

  assign rew_best = best_valid[selected_arm] ? best_seen[selected_arm] : {VAL_W{1'b1}};
  assign rew_imp  = key_q < rew_best;
  assign rew_drop = rew_best - key_q;
  assign rew_rel  = rew_imp && (reward_mode == MODE_RELATIVE) && best_valid[selected_arm] &&
                    (first_seen[selected_arm] != '0);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    log_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = (in_data.cmd == CMD_SELECT) ? S_SEL_INIT : S_REW;
      end
      S_SEL_INIT: begin
        if (total_pulls != '0) begin
          log_start  = 1'b1;
          state_next = S_SEL_LOG;
        end else begin
          state_next = S_SEL_ARM;
        end
      end
      S_SEL_LOG: begin
        if (log_stat.done) state_next = S_SEL_LN;
      end
      S_SEL_LN: state_next = S_SEL_T;
      S_SEL_T:  state_next = S_SEL_ARM;
      S_SEL_ARM: begin
        if (!mask_q[arm]) begin
          if (last_arm) state_next = S_SEL_END;
        end else if (arm_inf) begin
          state_next = S_SEL_CMP;
        end else begin
          div_start  = 1'b1;
          div_num    = arm_score[arm];
          div_den    = arm_pulls[arm];
          state_next = S_SEL_MEAN;
        end
      end
      S_SEL_MEAN: begin
        if (div_stat.done) begin
          div_start  = 1'b1;
          div_num    = SCORE_W'(t_q);
          div_den    = arm_pulls[arm];
          state_next = S_SEL_Q;
        end
      end
      S_SEL_Q: begin
        if (div_stat.done) begin
          sqrt_start = 1'b1;
          state_next = S_SEL_SQRT;
        end
      end
      S_SEL_SQRT: begin
        if (sqrt_stat.done) state_next = S_SEL_CMP;
      end
      S_SEL_CMP: state_next = last_arm ? S_SEL_END : S_SEL_ARM;
      S_SEL_END: state_next = S_DONE;
      S_REW: begin
        if (rew_rel) begin
          div_start  = 1'b1;
          div_num    = {1'b0, rew_drop, 16'h0000};
          div_den    = PULL_W'(first_seen[selected_arm]);
          state_next = S_REW_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REW_DIV: begin
        if (div_stat.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      explore_gain    <= GAIN_W'(512);
      count_once      <= 1'b0;
      reward_mode     <= MODE_NORMAL;
      total_pulls     <= '0;
      best_valid      <= '0;
      selected_arm    <= '0;
      fresh_selection <= 1'b0;
      out_valid       <= 1'b0;
      arm             <= '0;
      found           <= 1'b0;
      for (int i = 0; i < NUM_ARMS; i++) begin
        arm_score[i] <= '0;
        arm_pulls[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_GAIN: explore_gain <= cfg_data;
          CFG_ONCE: count_once   <= cfg_data[0];
          CFG_MODE: reward_mode  <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mask_q <= in_data.arm_available;
            key_q  <= in_data.new_value;
            arm    <= '0;
            found  <= 1'b0;
          end
        end
        S_SEL_LN: ln_q <= ln_prod[52:32];
        S_SEL_T:  t_q  <= T_W'(explore_gain) * T_W'(ln_q);
        S_SEL_ARM: begin
          if (!mask_q[arm]) begin
            if (!last_arm) arm <= arm + ARM_W'(1);
          end else if (arm_inf) begin
            val_q <= {CMPV_W{1'b1}};
          end
        end
        S_SEL_MEAN: begin
          if (div_stat.done) mean_q <= div_quot;
        end
        S_SEL_SQRT: begin
          if (sqrt_stat.done) val_q <= {2'b00, mean_q} + CMPV_W'(root);
        end
        S_SEL_CMP: begin
          if (!found || val_q > best_val) begin
            found    <= 1'b1;
            best_arm <= arm;
            best_val <= val_q;
          end
          if (!last_arm) arm <= arm + ARM_W'(1);
        end
        S_SEL_END: begin
          fresh_selection <= 1'b1;
          if (found) selected_arm <= best_arm;
          res_q <= '{chosen_arm: found ? best_arm : '0, arm_found: found, improved: 1'b0};
        end
        S_REW: begin
          if (!count_once || fresh_selection) begin
            if (arm_pulls[selected_arm] != '1)
              arm_pulls[selected_arm] <= arm_pulls[selected_arm] + PULL_W'(1);
            if (total_pulls != '1) total_pulls <= total_pulls + PULL_W'(1);
            fresh_selection <= 1'b0;
          end
          if (rew_imp) begin
            best_seen[selected_arm]  <= key_q;
            best_valid[selected_arm] <= 1'b1;
            if (reward_mode[1]) begin
              arm_score[selected_arm] <= sat_add(arm_score[selected_arm],
                                                 SCORE_W'(1) << 16);
            end else if (!best_valid[selected_arm]) begin
              first_seen[selected_arm] <= key_q;
            end else if (reward_mode == MODE_NORMAL) begin
              arm_score[selected_arm] <= sat_add(arm_score[selected_arm],
                                                 {1'b0, rew_drop, 16'h0000});
            end
          end
          res_q <= '{chosen_arm: selected_arm, arm_found: 1'b0, improved: rew_imp};
        end
        S_REW_DIV: begin
          if (div_stat.done)
            arm_score[selected_arm] <= sat_add(arm_score[selected_arm], div_quot);
        end
        S_DONE: begin
          if (out_free) out_data <= res_q;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_found_xor_improved: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.arm_found && out_data.improved))
    else $error("select and reward flags both set");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> total_pulls >= $past(total_pulls))
    else $error("total pulls decreased");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_SEL_MEAN || state == S_SEL_Q || state == S_REW_DIV))
    else $error("divider busy outside a dividing state");

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(div_stat.busy || log_stat.busy || sqrt_stat.busy))
    else $error("unit busy while idle");

endmodule

`default_nettype wire
